### design/oer_pkg.sv
// Shared types and constants of the owned edge reachability block.
// Holds the command codes, the sizes of the edge table and node set, and the
// control and status words that pass between oer_ctrl and oer_dpath.
package oer_pkg;

	localparam int NODE_CNT = 64;
	localparam int NODE_W   = 6;
	localparam int EDGE_CNT = 128;
	localparam int SLOT_W   = 7;
	localparam int TOTAL_W  = 8;
	localparam int PLAYER_W = 2;
	localparam int OWNER_W  = 3;
	localparam int ENDS_W   = 2 * NODE_W;

	localparam logic [OWNER_W-1:0] OWNER_FREE = '0;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_CLAIM = 2'd2,
		CMD_QUERY = 2'd3
	} cmd_t;

	// controller to datapath
	typedef struct packed {
		logic latch;     // capture the operand word
		logic apply;     // execute a non-sweeping command, load the result
		logic q_init;    // seed the visited set, rewind the sweep
		logic rd_en;     // read the edge at the sweep index, advance it
		logic pass_clr;  // rewind the sweep for another pass
		logic finish;    // load the query answer
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic is_query;  // latched command is a query
		logic trivial;   // query needs no sweep
		logic idx_last;  // sweep index sits on the last edge
		logic grow_now;  // edge under test adds a node this cycle
		logic grew;      // the current pass has added a node
	} stat_t;

endpackage

### design/oer_ctrl.sv
// Sequencer of the owned edge reachability block.
// Depends on oer_pkg; drives oer_dpath through ctl_t and reads stat_t.
module oer_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  oer_pkg::stat_t st,
	output oer_pkg::ctl_t  ctl,
	output logic          busy,
	output logic          done
);
	import oer_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SWEEP,
		S_LAST,
		S_DONE
	} state_t;

	state_t state_q, state_d;
	logic   done_q, done_d;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		done_d  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				ctl.latch = start;
				if (start) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (!st.is_query || st.trivial) begin
					ctl.apply = 1'b1;
					done_d    = 1'b1;
					state_d   = S_IDLE;
				end else begin
					ctl.q_init = 1'b1;
					state_d    = S_SWEEP;
				end
			end
			S_SWEEP: begin
				ctl.rd_en = 1'b1;
				if (st.idx_last) begin
					state_d = S_LAST;
				end
			end
			S_LAST: begin
				// last edge of the pass is tested now: go again while the set grows
				if (st.grew || st.grow_now) begin
					ctl.pass_clr = 1'b1;
					state_d      = S_SWEEP;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				ctl.finish = 1'b1;
				done_d     = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

### design/oer_dpath.sv
// Datapath of the owned edge reachability block: edge table memories,
// edge count, sweep index, visited set and result registers.
// Depends on oer_pkg; commanded by oer_ctrl through ctl_t.
module oer_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  oer_pkg::ctl_t                 ctl,
	input  logic [1:0]                    cmd,
	input  logic [oer_pkg::NODE_W-1:0]    node_from,
	input  logic [oer_pkg::NODE_W-1:0]    node_to,
	input  logic [oer_pkg::SLOT_W-1:0]    edge_slot,
	input  logic [oer_pkg::PLAYER_W-1:0]  player_id,
	output oer_pkg::stat_t                st,
	output logic                          joined,
	output logic                          status,
	output logic [oer_pkg::TOTAL_W-1:0]   edges_held
);
	import oer_pkg::*;

	// operand word
	cmd_t                cmd_q;
	logic [NODE_W-1:0]   from_q, to_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [PLAYER_W-1:0] player_q;

	// edge table
	logic [ENDS_W-1:0]  ends_mem  [EDGE_CNT];
	logic [OWNER_W-1:0] owner_mem [EDGE_CNT];
	logic [TOTAL_W-1:0] total_q;

	// sweep
	logic [SLOT_W-1:0]   idx_q;
	logic                rd_v_s1;
	logic [ENDS_W-1:0]   ends_s1;
	logic [OWNER_W-1:0]  owner_s1;
	logic [NODE_CNT-1:0] mask_q;
	logic                grew_q;

	logic                joined_q, status_q;

	logic [OWNER_W-1:0]  code;
	logic                same_node, full, slot_bad;
	logic [NODE_W-1:0]   end_p, end_q;
	logic                vis_p, vis_q;

	assign code      = OWNER_W'(player_q) + OWNER_W'(1);
	assign same_node = (from_q == to_q);
	assign full      = (total_q >= TOTAL_W'(EDGE_CNT));
	assign slot_bad  = ({1'b0, slot_q} >= total_q);

	assign end_p = ends_s1[ENDS_W-1:NODE_W];
	assign end_q = ends_s1[NODE_W-1:0];
	assign vis_p = mask_q[end_p];
	assign vis_q = mask_q[end_q];

	assign st.is_query = (cmd_q == CMD_QUERY);
	assign st.trivial  = same_node || (total_q == '0);
	assign st.idx_last = ({1'b0, idx_q} == (total_q - TOTAL_W'(1)));
	assign st.grow_now = rd_v_s1 && (owner_s1 == code) && (vis_p ^ vis_q);
	assign st.grew     = grew_q;

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q    <= cmd_t'(cmd);
			from_q   <= node_from;
			to_q     <= node_to;
			slot_q   <= edge_slot;
			player_q <= player_id;
		end
	end

	// table writes: append takes the slot at the count, claim rewrites an owner
	always_ff @(posedge clk) begin
		if (ctl.apply && cmd_q == CMD_ADD && !full) begin
			ends_mem[total_q[SLOT_W-1:0]]  <= {from_q, to_q};
			owner_mem[total_q[SLOT_W-1:0]] <= OWNER_FREE;
		end else if (ctl.apply && cmd_q == CMD_CLAIM && !slot_bad) begin
			owner_mem[slot_q] <= code;
		end
		if (ctl.rd_en) begin
			ends_s1  <= ends_mem[idx_q];
			owner_s1 <= owner_mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.q_init) begin
			mask_q <= NODE_CNT'(1) << from_q;
		end else if (st.grow_now) begin
			mask_q <= mask_q | (NODE_CNT'(1) << end_p) | (NODE_CNT'(1) << end_q);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.apply) begin
			unique case (cmd_q)
				CMD_CLEAR: begin
					joined_q <= 1'b0;
					status_q <= 1'b0;
				end
				CMD_ADD: begin
					joined_q <= 1'b0;
					status_q <= full;
				end
				CMD_CLAIM: begin
					joined_q <= 1'b0;
					status_q <= slot_bad;
				end
				CMD_QUERY: begin
					joined_q <= same_node;
					status_q <= 1'b0;
				end
				default: begin
					joined_q <= 1'b0;
					status_q <= 1'b0;
				end
			endcase
		end else if (ctl.finish) begin
			joined_q <= mask_q[to_q];
			status_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			idx_q   <= '0;
			rd_v_s1 <= 1'b0;
			grew_q  <= 1'b0;
		end else begin
			rd_v_s1 <= ctl.rd_en;
			if (ctl.apply && cmd_q == CMD_CLEAR) begin
				total_q <= '0;
			end else if (ctl.apply && cmd_q == CMD_ADD && !full) begin
				total_q <= total_q + TOTAL_W'(1);
			end
			if (ctl.q_init || ctl.pass_clr) begin
				idx_q <= '0;
			end else if (ctl.rd_en) begin
				idx_q <= idx_q + SLOT_W'(1);
			end
			if (ctl.q_init || ctl.pass_clr) begin
				grew_q <= 1'b0;
			end else if (st.grow_now) begin
				grew_q <= 1'b1;
			end
		end
	end

	assign joined     = joined_q;
	assign status     = status_q;
	assign edges_held = total_q;

endmodule

### design/owned_edge_reachability_core.sv
// Top level of the owned edge reachability block.
// Depends on oer_pkg; instantiates oer_ctrl and oer_dpath.
//
// Keeps a table of up to 128 undirected edges between nodes 0..63, each free
// or owned by one of four players. Drive a command word with start; it is
// taken at a rising edge where start is high and busy is low. Exactly one
// result word follows on joined, status and edges_held, marked by done for a
// single cycle; the receiver cannot stall it, so capture it when done is high.
// Clear, add and claim need no sweep, nor does a query with equal nodes or
// an empty table. Any other query floods a visited set by sweeping the
// edge table, one edge per cycle within a pass through a single registered
// memory read port. Passes repeat until one adds no node, and there are at
// most one more passes than the number of nodes the query reaches. The edge
// table needs no clearing after reset: only entries below the edge count
// are ever read.
module owned_edge_reachability_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [1:0]                    cmd,
	input  logic [oer_pkg::NODE_W-1:0]    node_from,
	input  logic [oer_pkg::NODE_W-1:0]    node_to,
	input  logic [oer_pkg::SLOT_W-1:0]    edge_slot,
	input  logic [oer_pkg::PLAYER_W-1:0]  player_id,
	output logic                          busy,
	output logic                          done,
	output logic                          joined,
	output logic                          status,
	output logic [oer_pkg::TOTAL_W-1:0]   edges_held
);
	import oer_pkg::*;

	ctl_t  ctl;
	stat_t st;

	// sequencer: decode, sweep passes, result strobe
	oer_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	// edge table, visited set and result registers
	oer_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.cmd        (cmd),
		.node_from  (node_from),
		.node_to    (node_to),
		.edge_slot  (edge_slot),
		.player_id  (player_id),
		.st         (st),
		.joined     (joined),
		.status     (status),
		.edges_held (edges_held)
	);

endmodule
